// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define TSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define TSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tsp_pkg.sv =====
// Types and constants of the time sorted point table.
package tsp_pkg;

    localparam int MAX_POINTS_DEF = 16;

    typedef enum logic [2:0] {
        REQ_ADD       = 3'd0,
        REQ_REMOVE    = 3'd1,
        REQ_GET_AT    = 3'd2,
        REQ_GET_ID    = 3'd3,
        REQ_NEXT_FREE = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [31:0] tstamp;
        logic [7:0]  id;
        logic [23:0] color;
    } t_point;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  entry_id;
        logic [31:0] point_time;
        logic [23:0] point_color;
        logic [7:0]  position;
    } t_in_beat;

    typedef struct packed {
        logic        ok;
        logic [7:0]  out_id;
        logic [31:0] out_time;
        logic [23:0] out_color;
        logic [7:0]  free_id;
        logic [4:0]  entry_count;
    } t_out_beat;

    // Request token walking down the cell row, one cell per cycle.
    typedef struct packed {
        logic        vld;
        logic        en;
        t_req        op;
        logic [7:0]  id;
        logic [31:0] tm;
        logic [23:0] col;
        logic [7:0]  position;
        logic        hit_pt;     // point placed / found / free id walk stopped
        logic        hit_id;     // id placed / found in ascending list
        t_point      carry;      // displaced point during insert
        logic [7:0]  carry_aid;  // displaced id during insert
        t_point      res;
        logic [7:0]  fid;
    } t_pkt;

endpackage

// ===== hw/rtl/tsp_cell.sv =====
// One table cell: a time-ordered slot, an ascending id entry and a token stage.
module tsp_cell #(
    parameter int CW       = 5,
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [CW-1:0]   i_count,
    input  tsp_pkg::t_pkt   i_pkt,
    output tsp_pkg::t_pkt   o_pkt,
    input  tsp_pkg::t_point i_right_slot,
    output tsp_pkg::t_point o_slot,
    input  logic [7:0]      i_right_aid,
    output logic [7:0]      o_aid
);

    localparam logic [CW-1:0] MY_IDX = CW'(CELL_IDX);
    localparam logic [7:0]    MY_POS = 8'(CELL_IDX);

    tsp_pkg::t_pkt   r_pkt, n_pkt;
    tsp_pkg::t_point r_slot, n_slot;
    logic [7:0]      r_aid, n_aid;
    logic            in_use;
    logic            at_end;
    tsp_pkg::t_point new_pt;

    always_comb begin
        in_use = MY_IDX < i_count;
        at_end = MY_IDX == i_count;
        new_pt = '{tstamp: i_pkt.tm, id: i_pkt.id, color: i_pkt.col};
        n_pkt  = i_pkt;
        n_slot = r_slot;
        n_aid  = r_aid;
        if (i_pkt.vld && i_pkt.en) begin
            unique case (i_pkt.op)
                tsp_pkg::REQ_ADD: begin
                    // insert ahead of the first equal or later time, then ripple right
                    if (!i_pkt.hit_pt) begin
                        if ((in_use && !(i_pkt.tm > r_slot.tstamp)) || at_end) begin
                            n_slot       = new_pt;
                            n_pkt.carry  = r_slot;
                            n_pkt.hit_pt = 1'b1;
                        end
                    end else if (in_use || at_end) begin
                        n_slot      = i_pkt.carry;
                        n_pkt.carry = r_slot;
                    end
                    if (!i_pkt.hit_id) begin
                        if ((in_use && !(i_pkt.id > r_aid)) || at_end) begin
                            n_aid           = i_pkt.id;
                            n_pkt.carry_aid = r_aid;
                            n_pkt.hit_id    = 1'b1;
                        end
                    end else if (in_use || at_end) begin
                        n_aid           = i_pkt.carry_aid;
                        n_pkt.carry_aid = r_aid;
                    end
                end
                tsp_pkg::REQ_REMOVE: begin
                    // from the match onward, pull the right neighbor in
                    if (in_use && !i_pkt.hit_pt && r_slot.id == i_pkt.id) begin
                        n_pkt.hit_pt = 1'b1;
                    end
                    if (in_use && n_pkt.hit_pt) begin
                        n_slot = i_right_slot;
                    end
                    if (in_use && !i_pkt.hit_id && r_aid == i_pkt.id) begin
                        n_pkt.hit_id = 1'b1;
                    end
                    if (in_use && n_pkt.hit_id) begin
                        n_aid = i_right_aid;
                    end
                end
                tsp_pkg::REQ_GET_AT: begin
                    if (in_use && i_pkt.position == MY_POS) begin
                        n_pkt.hit_pt = 1'b1;
                        n_pkt.res    = r_slot;
                    end
                end
                tsp_pkg::REQ_GET_ID: begin
                    if (in_use && !i_pkt.hit_pt && r_slot.id == i_pkt.id) begin
                        n_pkt.hit_pt = 1'b1;
                        n_pkt.res    = r_slot;
                    end
                end
                tsp_pkg::REQ_NEXT_FREE: begin
                    // first gap in the ascending ids stops the walk
                    if (in_use && !i_pkt.hit_pt) begin
                        if (r_aid == i_pkt.fid) begin
                            n_pkt.fid = i_pkt.fid + 8'd1;
                        end else begin
                            n_pkt.hit_pt = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_aid  <= n_aid;
        if (!i_rst_n) begin
            r_pkt.vld <= 1'b0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt  = r_pkt;
    assign o_slot = r_slot;
    assign o_aid  = r_aid;

endmodule

// ===== hw/rtl/tsp_ctrl.sv =====
// Request launch, entry count and result registers of the point table.
module tsp_ctrl #(
    parameter int MAX_POINTS = tsp_pkg::MAX_POINTS_DEF,
    parameter int CW         = $clog2(MAX_POINTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tsp_pkg::t_in_beat   i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tsp_pkg::t_out_beat  o_out,
    output tsp_pkg::t_pkt       o_pkt,
    input  tsp_pkg::t_pkt       i_pkt,
    output logic [CW-1:0]       o_count
);

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

    tsp_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    tsp_pkg::t_out_beat r_res, n_res;
    tsp_pkg::t_out_beat r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [CW-1:0]      cnt_next;
    logic               res_ok;
    tsp_pkg::t_req      in_op;

    always_comb begin
        in_op = tsp_pkg::t_req'(i_in.req_type);

        o_pkt           = '0;
        o_pkt.vld       = i_in_valid && (r_state == tsp_pkg::ST_IDLE);
        o_pkt.en        = (in_op != tsp_pkg::REQ_ADD) || (r_count < MAX_CNT);
        o_pkt.op        = in_op;
        o_pkt.id        = i_in.entry_id;
        o_pkt.tm        = i_in.point_time;
        o_pkt.col       = i_in.point_color;
        o_pkt.position  = i_in.position;

        cnt_next = r_count;
        res_ok   = 1'b0;
        case (i_pkt.op) inside
            tsp_pkg::REQ_ADD: begin
                res_ok = i_pkt.en;
                if (i_pkt.en) begin
                    cnt_next = r_count + CW'(1);
                end
            end
            tsp_pkg::REQ_REMOVE: begin
                res_ok = i_pkt.hit_pt;
                if (i_pkt.hit_pt) begin
                    cnt_next = r_count - CW'(1);
                end
            end
            tsp_pkg::REQ_GET_AT, tsp_pkg::REQ_GET_ID: begin
                res_ok = i_pkt.hit_pt;
            end
            tsp_pkg::REQ_NEXT_FREE: begin
                res_ok = 1'b1;
            end
            default: begin
            end
        endcase

        n_state     = r_state;
        n_count     = r_count;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = r_state != tsp_pkg::ST_IDLE;

        unique case (r_state)
            tsp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tsp_pkg::ST_RUN;
                end
            end
            tsp_pkg::ST_RUN: begin
                if (i_pkt.vld) begin
                    n_res.ok          = res_ok;
                    n_res.out_id      = i_pkt.res.id;
                    n_res.out_time    = i_pkt.res.tstamp;
                    n_res.out_color   = i_pkt.res.color;
                    n_res.free_id     = i_pkt.fid;
                    n_res.entry_count = 5'(cnt_next);
                    n_count           = cnt_next;
                    n_state           = tsp_pkg::ST_HOLD;
                end
            end
            tsp_pkg::ST_HOLD: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = tsp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;
    assign o_count     = r_count;

endmodule

// ===== hw/rtl/time_sorted_point_table.sv =====
// Channel   Handshake            Beat
// in        i_in_valid/o_in_stall  t_in_beat: request, id, time, color, position
// out       o_out_valid/i_out_stall t_out_beat: ok, point read, free id, count
//
// One request at a time: a token walks the row of MAX_POINTS cells, one cell
// per cycle; its result is registered in the result register and then in the
// output register that drives the result beat. The next request is taken while
// the last result still waits on a stalled output; a further result then holds
// the input until the output drains. Reset only clears the entry count, the
// token valid bits and the handshake state.
module time_sorted_point_table #(
    parameter int MAX_POINTS = tsp_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tsp_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tsp_pkg::t_out_beat o_out
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    tsp_pkg::t_pkt   chain_pkt  [MAX_POINTS+1];
    tsp_pkg::t_point slot_q     [MAX_POINTS];
    tsp_pkg::t_point right_slot [MAX_POINTS];
    logic [7:0]      aid_q      [MAX_POINTS];
    logic [7:0]      right_aid  [MAX_POINTS];
    logic [CW-1:0]   count;

    tsp_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_pkt       (chain_pkt[0]),
        .i_pkt       (chain_pkt[MAX_POINTS]),
        .o_count     (count)
    );

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        if (g == MAX_POINTS - 1) begin : g_last
            assign right_slot[g] = '0;
            assign right_aid[g]  = '0;
        end else begin : g_mid
            assign right_slot[g] = slot_q[g+1];
            assign right_aid[g]  = aid_q[g+1];
        end

        tsp_cell #(
            .CW       (CW),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_count      (count),
            .i_pkt        (chain_pkt[g]),
            .o_pkt        (chain_pkt[g+1]),
            .i_right_slot (right_slot[g]),
            .o_slot       (slot_q[g]),
            .i_right_aid  (right_aid[g]),
            .o_aid        (aid_q[g])
        );
    end

endmodule

// ===== hw/rtl/tsp_checker.sv =====
// Port-level checks of the point table, bound to the top level.
`include "assert_macros.svh"

module tsp_checker #(
    parameter int MAX_POINTS = tsp_pkg::MAX_POINTS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input tsp_pkg::t_in_beat  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tsp_pkg::t_out_beat o_out
);

    `TSP_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "stalled result beat changed")

    `TSP_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "second request taken while one is in flight")

    `TSP_ASSERT(a_count_bound, i_clk, i_rst_n, o_out_valid |-> (MAX_POINTS > 31 || o_out.entry_count <= 5'(MAX_POINTS)), "entry count above table size")

    `TSP_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid, "result beat right after reset")

endmodule

bind time_sorted_point_table tsp_checker #(.MAX_POINTS(MAX_POINTS)) u_tsp_checker (.*);

// ===== tb/time_sorted_point_table_checker.sv =====
// Checker for the time sorted point table: tracks the table, predicts each reply, compares.
`timescale 1ns / 1ps

module time_sorted_point_table_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  tsp_pkg::t_in_beat  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  tsp_pkg::t_out_beat i_out,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);

    localparam int DEPTH      = tsp_pkg::MAX_POINTS_DEF;
    localparam int PRINT_CAP  = 200;

    // points in time order, ids in ascending order
    logic [31:0] pt_time  [DEPTH];
    logic [7:0]  pt_id    [DEPTH];
    logic [23:0] pt_color [DEPTH];
    logic [7:0]  ids_up   [DEPTH];
    int          n_points = 0;

    tsp_pkg::t_out_beat replies_due [$];
    int                 err_count = 0;
    int                 reply_count = 0;

    assign o_errors  = err_count;
    assign o_pending = replies_due.size();
    assign o_checked = reply_count;

    task automatic report(input string what);
        err_count++;
        if (err_count <= PRINT_CAP) begin
            $display("[%0t] MISMATCH %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("reply %0d %s: got %0h, expected %0h",
                             reply_count, name, got, want));
        end
    endtask

    // first match in time order, n_points when absent
    function automatic int first_slot_of(input logic [7:0] id);
        int i;
        for (i = 0; i < n_points; i++) begin
            if (pt_id[i] == id) return i;
        end
        return n_points;
    endfunction

    task automatic model_table_request(input tsp_pkg::t_in_beat b,
                                       output tsp_pkg::t_out_beat r);
        int p;
        int q;
        int i;
        r = '0;
        case (b.req_type) inside
            tsp_pkg::REQ_ADD: begin
                if (n_points < DEPTH) begin
                    p = 0;
                    while (p < n_points && b.point_time > pt_time[p]) p++;
                    for (i = n_points; i > p; i--) begin
                        pt_time[i]  = pt_time[i-1];
                        pt_id[i]    = pt_id[i-1];
                        pt_color[i] = pt_color[i-1];
                    end
                    pt_time[p]  = b.point_time;
                    pt_id[p]    = b.entry_id;
                    pt_color[p] = b.point_color;
                    q = 0;
                    while (q < n_points && b.entry_id > ids_up[q]) q++;
                    for (i = n_points; i > q; i--) ids_up[i] = ids_up[i-1];
                    ids_up[q] = b.entry_id;
                    n_points++;
                    r.ok = 1'b1;
                end
            end
            tsp_pkg::REQ_REMOVE: begin
                p = first_slot_of(b.entry_id);
                q = 0;
                while (q < n_points && ids_up[q] != b.entry_id) q++;
                if (p < n_points && q < n_points) begin
                    for (i = p; i + 1 < n_points; i++) begin
                        pt_time[i]  = pt_time[i+1];
                        pt_id[i]    = pt_id[i+1];
                        pt_color[i] = pt_color[i+1];
                    end
                    for (i = q; i + 1 < n_points; i++) ids_up[i] = ids_up[i+1];
                    n_points--;
                    r.ok = 1'b1;
                end
            end
            tsp_pkg::REQ_GET_AT, tsp_pkg::REQ_GET_ID: begin
                p = (b.req_type == tsp_pkg::REQ_GET_AT) ? int'(b.position)
                                                        : first_slot_of(b.entry_id);
                if (p < n_points) begin
                    r.ok        = 1'b1;
                    r.out_id    = pt_id[p];
                    r.out_time  = pt_time[p];
                    r.out_color = pt_color[p];
                end
            end
            tsp_pkg::REQ_NEXT_FREE: begin
                // walk the ascending list until the first gap
                for (i = 0; i < n_points; i++) begin
                    if (ids_up[i] != r.free_id) break;
                    r.free_id++;
                end
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.entry_count = 5'(n_points);
    endtask

    always @(posedge i_clk) begin
        tsp_pkg::t_out_beat want;
        if (!i_rst_n) begin
            n_points = 0;
            replies_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                reply_count++;
                if (replies_due.size() == 0) begin
                    report($sformatf("reply %0d arrived with nothing pending: %h",
                                     reply_count, i_out));
                end else begin
                    want = replies_due.pop_front();
                    check_field("ok",          32'(i_out.ok),          32'(want.ok));
                    check_field("out_id",      32'(i_out.out_id),      32'(want.out_id));
                    check_field("out_time",    i_out.out_time,         want.out_time);
                    check_field("out_color",   32'(i_out.out_color),   32'(want.out_color));
                    check_field("free_id",     32'(i_out.free_id),     32'(want.free_id));
                    check_field("entry_count", 32'(i_out.entry_count), 32'(want.entry_count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                model_table_request(i_in, want);
                replies_due.push_back(want);
            end
        end
    end

endmodule

// ===== tb/time_sorted_point_table_test.sv =====
// Top of the time sorted point table test: clock, reset, request traffic, reply stalls, verdict.
`timescale 1ns / 1ps

module time_sorted_point_table_test;

    localparam int         NUM_RANDOM    = 1750;
    localparam int         DRAIN_CYCLES  = 2 * (tsp_pkg::MAX_POINTS_DEF + 3) + 10;
    localparam int         SETTLE_CAP    = 5000;
    localparam logic [2:0] REQ_UNDEFINED = 3'd7;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_kind;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    tsp_pkg::t_in_beat  in_beat   = '0;
    logic               in_stall;
    logic               out_valid;
    logic               out_stall = 1'b0;
    tsp_pkg::t_out_beat out_beat;

    int          errors;
    int          pending;
    int          checked;
    int          sent_by_type [8];
    int          burst_left = 0;
    logic [15:0] stall_cycle = '0;
    t_stall_kind stall_mode = STALL_NONE;

    time_sorted_point_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    time_sorted_point_table_checker table_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_beat),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #6_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // reply side: pick a new random stall style whenever stall_cycle[7:0] reaches FF
    always @(posedge clk) begin
        if (!rst_n) begin
            stall_cycle <= '0;
            stall_mode  <= STALL_NONE;
            out_stall   <= 1'b0;
        end else begin
            stall_cycle <= stall_cycle + 16'd1;
            if (stall_cycle[7:0] == 8'hFF) begin
                stall_mode <= t_stall_kind'($urandom_range(0, 3));
            end
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    out_stall <= (stall_cycle[2:0] != 3'd0);
                STALL_PERIODIC: out_stall <= stall_cycle[4];
                default:        out_stall <= 1'b0;
            endcase
        end
    end

    function automatic tsp_pkg::t_in_beat make_req(input logic [2:0] op,
                                                   input logic [7:0] id,
                                                   input logic [31:0] tm,
                                                   input logic [23:0] col,
                                                   input logic [7:0] pos);
        tsp_pkg::t_in_beat b;
        b.req_type    = op;
        b.entry_id    = id;
        b.point_time  = tm;
        b.point_color = col;
        b.position    = pos;
        return b;
    endfunction

    // ids mostly from a small pool so removes and lookups hit, ties in time are common
    function automatic tsp_pkg::t_in_beat random_request(input int add_weight);
        tsp_pkg::t_in_beat b;
        int                r;
        r = $urandom_range(0, 99);
        if (r < add_weight) begin
            b.req_type = tsp_pkg::REQ_ADD;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 35)      b.req_type = tsp_pkg::REQ_REMOVE;
            else if (r < 55) b.req_type = tsp_pkg::REQ_GET_AT;
            else if (r < 75) b.req_type = tsp_pkg::REQ_GET_ID;
            else if (r < 97) b.req_type = tsp_pkg::REQ_NEXT_FREE;
            else             b.req_type = 3'(tsp_pkg::REQ_NEXT_FREE + $urandom_range(1, 3));
        end
        r = $urandom_range(0, 99);
        if (r < 70)      b.entry_id = 8'($urandom_range(0, 19));
        else if (r < 80) b.entry_id = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else             b.entry_id = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 40)      b.point_time = 32'($urandom_range(0, 7));
        else if (r < 50) b.point_time = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        else             b.point_time = $urandom();
        r = $urandom_range(0, 99);
        if (r < 10)      b.point_color = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h0;
        else             b.point_color = 24'($urandom());
        r = $urandom_range(0, 99);
        if (r < 60)      b.position = 8'($urandom_range(0, tsp_pkg::MAX_POINTS_DEF));
        else if (r < 70) b.position = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else             b.position = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // one beat, held until taken; bursts with random idle gaps in between
    task automatic send(input tsp_pkg::t_in_beat b);
        int idle;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (idle > 0) begin
                in_valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
        burst_left--;
        in_beat  <= b;
        in_valid <= 1'b1;
        sent_by_type[b.req_type]++;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial begin
        int add_weight;
        int waited;
        int total;
        add_weight = 25;
        waited = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: nothing to find, free id is zero
        send(make_req(tsp_pkg::REQ_NEXT_FREE, 8'd0,   32'd0, 24'd0, 8'd0));
        send(make_req(tsp_pkg::REQ_GET_AT,    8'd0,   32'd0, 24'd0, 8'd0));
        send(make_req(tsp_pkg::REQ_GET_ID,    8'd0,   32'd0, 24'd0, 8'd0));
        send(make_req(tsp_pkg::REQ_REMOVE,    8'd200, 32'd0, 24'd0, 8'd0));
        // field extremes, equal time goes ahead, duplicate id
        send(make_req(tsp_pkg::REQ_ADD,       8'hFF,  '1,    '1,    8'hFF));
        send(make_req(tsp_pkg::REQ_ADD,       8'h00,  32'd0, 24'd0, 8'd0));
        send(make_req(tsp_pkg::REQ_ADD,       8'd1,   '1,    24'h5A5A5A, 8'd0));
        send(make_req(tsp_pkg::REQ_ADD,       8'd1,   32'd5, 24'hA5A5A5, 8'd0));
        send(make_req(tsp_pkg::REQ_GET_AT,    8'd0,   32'd0, 24'd0, 8'hFF));
        send(make_req(tsp_pkg::REQ_GET_AT,    8'd0,   32'd0, 24'd0, 8'd3));
        send(make_req(tsp_pkg::REQ_GET_ID,    8'd1,   32'd0, 24'd0, 8'd0));
        send(make_req(tsp_pkg::REQ_REMOVE,    8'd1,   32'd0, 24'd0, 8'd0));
        send(make_req(tsp_pkg::REQ_NEXT_FREE, 8'd0,   32'd0, 24'd0, 8'd0));
        send(make_req(REQ_UNDEFINED,          8'd1,   32'd5, 24'd0, 8'd0));
        // fill up, then one add too many
        for (int k = 2; k < 15; k++) begin
            send(make_req(tsp_pkg::REQ_ADD, 8'(k), 32'(k * 1000), 24'(k), 8'd0));
        end
        send(make_req(tsp_pkg::REQ_ADD,       8'd99,  32'd7, 24'd7, 8'd0));
        send(make_req(tsp_pkg::REQ_GET_AT,    8'd0,   32'd0, 24'd0,
                      8'(tsp_pkg::MAX_POINTS_DEF - 1)));
        send(make_req(tsp_pkg::REQ_NEXT_FREE, 8'd0,   32'd0, 24'd0, 8'd0));

        // segments lean toward filling, draining or holding the table level
        for (int k = 0; k < NUM_RANDOM; k++) begin
            if (k % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       add_weight = 10;
                    1:       add_weight = 25;
                    default: add_weight = 60;
                endcase
            end
            send(random_request(add_weight));
        end
        in_valid <= 1'b0;

        while (pending != 0 && waited < SETTLE_CAP) begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        total = 0;
        foreach (sent_by_type[i]) total += sent_by_type[i];
        $display("%0d requests: %0d add, %0d remove, %0d index read, %0d id read,",
                 total, sent_by_type[tsp_pkg::REQ_ADD], sent_by_type[tsp_pkg::REQ_REMOVE],
                 sent_by_type[tsp_pkg::REQ_GET_AT], sent_by_type[tsp_pkg::REQ_GET_ID]);
        $display("  %0d free id, %0d undefined; %0d replies compared, %0d mismatches, %0d missing",
                 sent_by_type[tsp_pkg::REQ_NEXT_FREE], total - sent_by_type[tsp_pkg::REQ_ADD]
                 - sent_by_type[tsp_pkg::REQ_REMOVE] - sent_by_type[tsp_pkg::REQ_GET_AT]
                 - sent_by_type[tsp_pkg::REQ_GET_ID] - sent_by_type[tsp_pkg::REQ_NEXT_FREE],
                 checked, errors, pending);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
